/* hw/rtl/vlw3d_pkg.sv */
// Shared types and constants for the 3D voxel line walker.
// Item structs, axis codes and the minor-axis ordering helpers.
// No dependencies.
package vlw3d_pkg;

    localparam int COORD_BITS = 10;
    localparam int STEP_BITS  = COORD_BITS + 1;
    // errors stay within +/- 2*(2^COORD_BITS - 1); one spare bit on top
    localparam int ERR_BITS   = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [STEP_BITS-1:0]  t_steps;
    typedef logic [ERR_BITS-1:0]   t_err;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef enum logic {
        MODE_START   = 1'b0,
        MODE_ADVANCE = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode  mode;
        t_coord start_x;
        t_coord start_y;
        t_coord start_z;
        t_coord end_x;
        t_coord end_y;
        t_coord end_z;
    } t_in_item;

    typedef struct packed {
        t_coord voxel_x;
        t_coord voxel_y;
        t_coord voxel_z;
        logic   last_voxel;
        logic   idle;
    } t_out_item;

    // first minor axis for a given major axis
    function automatic t_axis minor_a(input t_axis major);
        t_axis res;
        unique case (major)
            AXIS_X:  res = AXIS_Y;
            default: res = AXIS_X;
        endcase
        return res;
    endfunction

    // second minor axis for a given major axis
    function automatic t_axis minor_b(input t_axis major);
        t_axis res;
        unique case (major)
            AXIS_Z:  res = AXIS_Y;
            default: res = AXIS_Z;
        endcase
        return res;
    endfunction

endpackage

/* hw/rtl/voxel_line_walker_3d_core.sv */
// Top level of the 3D voxel line walker: face-connected Bresenham walk.
// Uses vlw3d_pkg for item structs, axis codes and widths.
//
// channel | direction | handshake                     | payload
// --------+-----------+-------------------------------+-----------------------
// in      | input     | i_in_valid / o_in_ready       | i_in_item  (t_in_item)
// out     | output    | o_out_valid / i_out_ready     | o_out_item (t_out_item)
//
// One item per cycle while the result is free or taken; each result is registered, shown the cycle after acceptance.
// The walk state and the result register are updated at the same edge, so
// the state update path (one add/compare on registered errors) sets the rate.
// A result held by a stalled consumer blocks new items until it is taken.
// Reset (synchronous, active low) drops any line and empties the result reg.
module voxel_line_walker_3d_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  vlw3d_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output vlw3d_pkg::t_out_item  o_out_item
);

    // walk state
    vlw3d_pkg::t_coord  r_cur_x, r_cur_y, r_cur_z;
    vlw3d_pkg::t_coord  n_cur_x, n_cur_y, n_cur_z;
    logic [2:0]         r_dir, n_dir;           // per axis, 1 = +1 step
    vlw3d_pkg::t_axis   r_major, n_major;
    vlw3d_pkg::t_axis   r_axis_a, n_axis_a;
    vlw3d_pkg::t_axis   r_axis_b, n_axis_b;
    vlw3d_pkg::t_coord  r_dmaj, n_dmaj;         // deltas in role order
    vlw3d_pkg::t_coord  r_da, n_da;
    vlw3d_pkg::t_coord  r_db, n_db;
    vlw3d_pkg::t_err    r_err_a, n_err_a;
    vlw3d_pkg::t_err    r_err_b, n_err_b;
    vlw3d_pkg::t_steps  r_steps, n_steps;
    logic               r_active, n_active;

    // result register
    logic                  r_out_valid;
    vlw3d_pkg::t_out_item  r_out_item, n_out_item;

    logic                  in_accept;
    vlw3d_pkg::t_coord     dx, dy, dz;
    logic                  dir_x, dir_y, dir_z;
    vlw3d_pkg::t_axis      start_major;
    vlw3d_pkg::t_axis      move_axis;
    logic                  do_move;
    vlw3d_pkg::t_err       twice_maj, twice_a, twice_b;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    function automatic vlw3d_pkg::t_coord step_coord(
        input vlw3d_pkg::t_coord c,
        input logic              dir,
        input logic              en
    );
        vlw3d_pkg::t_coord res;
        if (!en) begin
            res = c;
        end else if (dir) begin
            res = c + vlw3d_pkg::COORD_BITS'(1);
        end else begin
            res = c - vlw3d_pkg::COORD_BITS'(1);
        end
        return res;
    endfunction

    // start-time deltas and directions
    always_comb begin
        dir_x = i_in_item.end_x > i_in_item.start_x;
        dir_y = i_in_item.end_y > i_in_item.start_y;
        dir_z = i_in_item.end_z > i_in_item.start_z;
        dx = dir_x ? i_in_item.end_x - i_in_item.start_x
                   : i_in_item.start_x - i_in_item.end_x;
        dy = dir_y ? i_in_item.end_y - i_in_item.start_y
                   : i_in_item.start_y - i_in_item.end_y;
        dz = dir_z ? i_in_item.end_z - i_in_item.start_z
                   : i_in_item.start_z - i_in_item.end_z;
        // ties go to y, then x
        if (dy >= dx && dy >= dz) begin
            start_major = vlw3d_pkg::AXIS_Y;
        end else if (dx >= dy && dx >= dz) begin
            start_major = vlw3d_pkg::AXIS_X;
        end else begin
            start_major = vlw3d_pkg::AXIS_Z;
        end
    end

    assign twice_maj = vlw3d_pkg::ERR_BITS'({r_dmaj, 1'b0});
    assign twice_a   = vlw3d_pkg::ERR_BITS'({r_da, 1'b0});
    assign twice_b   = vlw3d_pkg::ERR_BITS'({r_db, 1'b0});

    always_comb begin
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_cur_z    = r_cur_z;
        n_dir      = r_dir;
        n_major    = r_major;
        n_axis_a   = r_axis_a;
        n_axis_b   = r_axis_b;
        n_dmaj     = r_dmaj;
        n_da       = r_da;
        n_db       = r_db;
        n_err_a    = r_err_a;
        n_err_b    = r_err_b;
        n_steps    = r_steps;
        n_active   = r_active;
        move_axis  = r_major;
        do_move    = 1'b0;
        n_out_item = '0;

        if (i_in_item.mode == vlw3d_pkg::MODE_START) begin
            n_cur_x  = i_in_item.start_x;
            n_cur_y  = i_in_item.start_y;
            n_cur_z  = i_in_item.start_z;
            n_dir    = {dir_z, dir_y, dir_x};
            n_major  = start_major;
            n_axis_a = vlw3d_pkg::minor_a(start_major);
            n_axis_b = vlw3d_pkg::minor_b(start_major);
            unique case (start_major)
                vlw3d_pkg::AXIS_X: begin
                    n_dmaj = dx; n_da = dy; n_db = dz;
                end
                vlw3d_pkg::AXIS_Y: begin
                    n_dmaj = dy; n_da = dx; n_db = dz;
                end
                default: begin
                    n_dmaj = dz; n_da = dx; n_db = dy;
                end
            endcase
            n_err_a  = vlw3d_pkg::ERR_BITS'(n_da) - vlw3d_pkg::ERR_BITS'(n_dmaj);
            n_err_b  = vlw3d_pkg::ERR_BITS'(n_db) - vlw3d_pkg::ERR_BITS'(n_dmaj);
            n_steps  = vlw3d_pkg::STEP_BITS'(n_dmaj);
            n_active = (n_dmaj != '0);
            n_out_item.voxel_x    = n_cur_x;
            n_out_item.voxel_y    = n_cur_y;
            n_out_item.voxel_z    = n_cur_z;
            n_out_item.last_voxel = !n_active;
        end else if (!r_active) begin
            n_out_item.idle = 1'b1;
        end else begin
            do_move = 1'b1;
            // sign bit clear means error >= 0
            if (!r_err_a[vlw3d_pkg::ERR_BITS-1]) begin
                move_axis = r_axis_a;
                n_err_a   = r_err_a - twice_maj;
            end else if (!r_err_b[vlw3d_pkg::ERR_BITS-1]) begin
                move_axis = r_axis_b;
                n_err_b   = r_err_b - twice_maj;
            end else begin
                move_axis = r_major;
                n_err_a   = r_err_a + twice_a;
                n_err_b   = r_err_b + twice_b;
                n_steps   = r_steps - vlw3d_pkg::STEP_BITS'(1);
                if (n_steps == '0) begin
                    n_active              = 1'b0;
                    n_out_item.last_voxel = 1'b1;
                end
            end
            n_cur_x = step_coord(r_cur_x, r_dir[0],
                                 move_axis == vlw3d_pkg::AXIS_X);
            n_cur_y = step_coord(r_cur_y, r_dir[1],
                                 move_axis == vlw3d_pkg::AXIS_Y);
            n_cur_z = step_coord(r_cur_z, r_dir[2],
                                 move_axis == vlw3d_pkg::AXIS_Z);
            n_out_item.voxel_x = n_cur_x;
            n_out_item.voxel_y = n_cur_y;
            n_out_item.voxel_z = n_cur_z;
        end
        if (!do_move) begin
            move_axis = r_major;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_cur_z     <= '0;
            r_dir       <= '0;
            r_major     <= vlw3d_pkg::AXIS_X;
            r_axis_a    <= vlw3d_pkg::AXIS_Y;
            r_axis_b    <= vlw3d_pkg::AXIS_Z;
            r_dmaj      <= '0;
            r_da        <= '0;
            r_db        <= '0;
            r_err_a     <= '0;
            r_err_b     <= '0;
            r_steps     <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_cur_x  <= n_cur_x;
                r_cur_y  <= n_cur_y;
                r_cur_z  <= n_cur_z;
                r_dir    <= n_dir;
                r_major  <= n_major;
                r_axis_a <= n_axis_a;
                r_axis_b <= n_axis_b;
                r_dmaj   <= n_dmaj;
                r_da     <= n_da;
                r_db     <= n_db;
                r_err_a  <= n_err_a;
                r_err_b  <= n_err_b;
                r_steps  <= n_steps;
                r_active <= n_active;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_item <= n_out_item;
        end
    end

    // an active line always has major steps left
    a_active_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_steps != '0))
        else $error("active line with no steps left");

    // a held last voxel means the line has ended
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready && o_out_item.last_voxel) |-> !r_active)
        else $error("last voxel shown while line still active");

    // advance with no line gives an idle result
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_item.mode == vlw3d_pkg::MODE_ADVANCE && !r_active)
        |=> (o_out_valid && o_out_item.idle))
        else $error("advance without line did not report idle");

    // idle results carry zero coordinates and no last flag
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.idle) |->
        (o_out_item.voxel_x == '0 && o_out_item.voxel_y == '0 &&
         o_out_item.voxel_z == '0 && !o_out_item.last_voxel))
        else $error("idle result with nonzero payload");

endmodule

/* tb/tb.sv */
// Self-checking testbench for voxel_line_walker_3d_core: 3D voxel line walks,
// advance items with no line active, restarts and output back-pressure.
// Depends on vlw3d_pkg for the item structs, mode and axis codes.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_MAX   = (1 << vlw3d_pkg::COORD_BITS) - 1;
    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 80;
    localparam int RAND_ITEMS  = 1870;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    vlw3d_pkg::t_in_item  i_in_item = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    vlw3d_pkg::t_out_item o_out_item;

    voxel_line_walker_3d_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // walk state mirrored by the predictor
    vlw3d_pkg::t_coord walk_pos[3];
    int                walk_dist[3];
    bit                walk_up[3];
    vlw3d_pkg::t_axis  walk_major = vlw3d_pkg::AXIS_X;
    int                walk_err[2];
    int                walk_left = 0;
    bit                walk_on = 1'b0;

    vlw3d_pkg::t_out_item expected_voxels[$];

    int  err_cnt = 0;
    int  voxels_checked = 0;
    int  line_ends = 0;
    int  idle_advances = 0;
    int  items_sent = 0;
    int  cycle_cnt = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    int  hold_reqs = 0;
    int  hold_seen = 0;
    int  hold_cnt = 0;

    initial begin
        for (int a = 0; a < 3; a++) begin
            walk_pos[a] = '0;
            walk_dist[a] = 0;
            walk_up[a] = 1'b0;
        end
        walk_err[0] = 0;
        walk_err[1] = 0;
    end

    function automatic void step_axis(input int a);
        walk_pos[a] = walk_up[a] ? walk_pos[a] + 1'b1 : walk_pos[a] - 1'b1;
    endfunction

    function automatic vlw3d_pkg::t_out_item predict_voxel(input vlw3d_pkg::t_in_item it);
        vlw3d_pkg::t_out_item res;
        int org[3];
        int fin[3];
        int ia;
        int ib;
        int mj;
        res = '0;
        if (it.mode == vlw3d_pkg::MODE_START) begin
            org[vlw3d_pkg::AXIS_X] = it.start_x;
            org[vlw3d_pkg::AXIS_Y] = it.start_y;
            org[vlw3d_pkg::AXIS_Z] = it.start_z;
            fin[vlw3d_pkg::AXIS_X] = it.end_x;
            fin[vlw3d_pkg::AXIS_Y] = it.end_y;
            fin[vlw3d_pkg::AXIS_Z] = it.end_z;
            for (int a = 0; a < 3; a++) begin
                walk_pos[a] = org[a];
                walk_up[a] = fin[a] > org[a];
                walk_dist[a] = walk_up[a] ? fin[a] - org[a] : org[a] - fin[a];
            end
            if (walk_dist[vlw3d_pkg::AXIS_Y] >= walk_dist[vlw3d_pkg::AXIS_X] &&
                walk_dist[vlw3d_pkg::AXIS_Y] >= walk_dist[vlw3d_pkg::AXIS_Z])
                walk_major = vlw3d_pkg::AXIS_Y;
            else if (walk_dist[vlw3d_pkg::AXIS_X] >= walk_dist[vlw3d_pkg::AXIS_Z])
                walk_major = vlw3d_pkg::AXIS_X;
            else
                walk_major = vlw3d_pkg::AXIS_Z;
        end else if (!walk_on) begin
            res.idle = 1'b1;
            return res;
        end
        case (walk_major)
            vlw3d_pkg::AXIS_X: begin
                ia = vlw3d_pkg::AXIS_Y;
                ib = vlw3d_pkg::AXIS_Z;
            end
            vlw3d_pkg::AXIS_Y: begin
                ia = vlw3d_pkg::AXIS_X;
                ib = vlw3d_pkg::AXIS_Z;
            end
            default: begin
                ia = vlw3d_pkg::AXIS_X;
                ib = vlw3d_pkg::AXIS_Y;
            end
        endcase
        mj = walk_major;
        if (it.mode == vlw3d_pkg::MODE_START) begin
            walk_err[0] = walk_dist[ia] - walk_dist[mj];
            walk_err[1] = walk_dist[ib] - walk_dist[mj];
            walk_left = walk_dist[mj];
            walk_on = walk_left != 0;
            res.last_voxel = !walk_on;
        end else if (walk_err[0] >= 0) begin
            step_axis(ia);
            walk_err[0] -= 2 * walk_dist[mj];
        end else if (walk_err[1] >= 0) begin
            step_axis(ib);
            walk_err[1] -= 2 * walk_dist[mj];
        end else begin
            step_axis(mj);
            walk_err[0] += 2 * walk_dist[ia];
            walk_err[1] += 2 * walk_dist[ib];
            walk_left--;
            if (walk_left == 0) begin
                walk_on = 1'b0;
                res.last_voxel = 1'b1;
            end
        end
        res.voxel_x = walk_pos[vlw3d_pkg::AXIS_X];
        res.voxel_y = walk_pos[vlw3d_pkg::AXIS_Y];
        res.voxel_z = walk_pos[vlw3d_pkg::AXIS_Z];
        return res;
    endfunction

    // accepted items are predicted before results are popped, all in one process
    always @(posedge i_clk) begin : scoreboard
        vlw3d_pkg::t_out_item want;
        if (i_rst_n && i_in_valid && o_in_ready)
            expected_voxels.push_back(predict_voxel(i_in_item));
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_voxels.size() == 0) begin
                if (err_cnt < 10)
                    $display("%0t: unexpected voxel (%0d,%0d,%0d) last=%0b idle=%0b",
                             $realtime,
                             o_out_item.voxel_x, o_out_item.voxel_y, o_out_item.voxel_z,
                             o_out_item.last_voxel, o_out_item.idle);
                err_cnt++;
            end else begin
                want = expected_voxels.pop_front();
                voxels_checked++;
                if (want.last_voxel)
                    line_ends++;
                if (want.idle)
                    idle_advances++;
                if (o_out_item.voxel_x !== want.voxel_x ||
                    o_out_item.voxel_y !== want.voxel_y ||
                    o_out_item.voxel_z !== want.voxel_z ||
                    o_out_item.last_voxel !== want.last_voxel ||
                    o_out_item.idle !== want.idle) begin
                    if (err_cnt < 10)
                        $display({"%0t: voxel mismatch: want (%0d,%0d,%0d) last=%0b idle=%0b,",
                                  " got (%0d,%0d,%0d) last=%0b idle=%0b"},
                                 $realtime, want.voxel_x, want.voxel_y, want.voxel_z,
                                 want.last_voxel, want.idle,
                                 o_out_item.voxel_x, o_out_item.voxel_y, o_out_item.voxel_z,
                                 o_out_item.last_voxel, o_out_item.idle);
                    err_cnt++;
                end
            end
        end
    end

    // consumer: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin : receiver
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= rx_quiet || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d voxels outstanding", cycle_cnt,
                     expected_voxels.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // valid stays high from one item to the next unless a gap is inserted
    task automatic send_item(input vlw3d_pkg::t_in_item it);
        if (!tx_quiet && $urandom_range(99) < 24) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 24);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    function automatic vlw3d_pkg::t_in_item start_item(input int sx, sy, sz, ex, ey, ez);
        vlw3d_pkg::t_in_item it;
        it.mode = vlw3d_pkg::MODE_START;
        it.start_x = sx;
        it.start_y = sy;
        it.start_z = sz;
        it.end_x = ex;
        it.end_y = ey;
        it.end_z = ez;
        return it;
    endfunction

    // endpoint fields of an advance are ignored; fill them with junk
    function automatic vlw3d_pkg::t_in_item advance_item();
        vlw3d_pkg::t_in_item it;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        it = raw[$bits(vlw3d_pkg::t_in_item)-1:0];
        it.mode = vlw3d_pkg::MODE_ADVANCE;
        return it;
    endfunction

    function automatic int line_steps(input int sx, sy, sz, ex, ey, ez);
        return (ex > sx ? ex - sx : sx - ex) + (ey > sy ? ey - sy : sy - ey) +
               (ez > sz ? ez - sz : sz - ez);
    endfunction

    // start a line, then issue advances; a negative count walks it to its end
    task automatic walk_line(input int sx, sy, sz, ex, ey, ez, input int advances);
        if (advances < 0)
            advances = line_steps(sx, sy, sz, ex, ey, ez);
        send_item(start_item(sx, sy, sz, ex, ey, ez));
        repeat (advances) send_item(advance_item());
    endtask

    function automatic int near_coord(input int s, input int span);
        int v;
        v = s + int'($urandom_range(2 * span)) - span;
        return v < 0 ? 0 : (v > COORD_MAX ? COORD_MAX : v);
    endfunction

    task automatic test_no_line_and_zero_length();
        vlw3d_pkg::t_in_item junk;
        junk = '1;
        junk.mode = vlw3d_pkg::MODE_ADVANCE;
        send_item(junk);
        // zero-length line at the top corner, then an advance past it
        walk_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1);
    endtask

    task automatic test_major_axes();
        walk_line(0, 0, 0, 1, 1, 1, -1);                   // three-way tie: y leads
        walk_line(COORD_MAX, 5, 0, COORD_MAX - 3, 4, 1, -1); // x major, negative x
        walk_line(0, 0, COORD_MAX, 0, 0, COORD_MAX - 2, -1); // z major, downward
        walk_line(0, 0, 0, 2, 0, 2, -1);                   // x/z tie: x leads
    endtask

    task automatic test_restart_mid_line();
        walk_line(10, 10, 10, 20, 10, 10, 2);
        walk_line(0, COORD_MAX, 0, 0, COORD_MAX - 3, 0, -1);
    endtask

    // input keeps offering items while the output is held off
    task automatic test_backpressure();
        tx_quiet = 1'b1;
        hold_reqs++;
        walk_line(100, 200, 300, 130, 190, 305, -1);
        tx_quiet = 1'b0;
    endtask

    task automatic test_random_walks(input int n_items);
        int base;
        int sx, sy, sz, ex, ey, ez;
        int span;
        int steps;
        int pick;
        logic [63:0] raw;
        base = items_sent;
        while (items_sent - base < n_items) begin
            tx_quiet = (items_sent - base >= 600) && (items_sent - base < 900);
            rx_quiet = tx_quiet;
            pick = $urandom_range(99);
            if (pick < 12) begin
                raw = {$urandom, $urandom};
                send_item(raw[$bits(vlw3d_pkg::t_in_item)-1:0]);
            end else begin
                if ($urandom_range(59) == 0)
                    span = 200;
                else if ($urandom_range(3) == 0)
                    span = 1;
                else
                    span = 12;
                sx = $urandom_range(COORD_MAX);
                sy = $urandom_range(COORD_MAX);
                sz = $urandom_range(COORD_MAX);
                ex = near_coord(sx, span);
                ey = near_coord(sy, span);
                ez = near_coord(sz, span);
                steps = line_steps(sx, sy, sz, ex, ey, ez);
                pick = $urandom_range(99);
                if (pick < 10)
                    steps = $urandom_range(steps);      // dropped by the next start
                else if (pick < 20)
                    steps += $urandom_range(2, 1);      // advances past the end
                walk_line(sx, sy, sz, ex, ey, ez, steps);
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial begin
        int leftover;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_no_line_and_zero_length();
        test_major_axes();
        test_restart_mid_line();
        test_backpressure();
        test_random_walks(RAND_ITEMS);

        i_in_valid <= 1'b0;
        for (int k = 0; k < 2000 && expected_voxels.size() > 0; k++)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        leftover = expected_voxels.size();
        if (leftover > 0)
            $display("%0d expected voxels never arrived", leftover);

        $display("Walked %0d items: %0d voxels checked, %0d line ends, %0d idle advances,",
                 items_sent, voxels_checked, line_ends, idle_advances);
        $display("with random gaps on both sides and one long output hold-off.");
        if (err_cnt == 0 && leftover == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
